// ===== src/hmm_vit_pkg.sv =====
package hmm_vit_pkg;

    localparam int WGT_W = 16;
    localparam int MET_W = 24;
    localparam int CFG_W = 4;

    localparam int DEF_NUM_STATES  = 8;
    localparam int DEF_NUM_SYMBOLS = 16;
    localparam int DEF_MAX_LEN     = 64;

    localparam logic signed [WGT_W-1:0] LOG_ZERO = {1'b1, {(WGT_W-1){1'b0}}};
    localparam logic signed [MET_W-1:0] MET_MIN  = {1'b1, {(MET_W-1){1'b0}}};
    localparam logic signed [MET_W-1:0] MET_MAX  = {1'b0, {(MET_W-1){1'b1}}};

    typedef enum logic [1:0] {
        KIND_TRANS   = 2'd0,
        KIND_EMIS    = 2'd1,
        KIND_INIT    = 2'd2,
        KIND_OBSERVE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ACS,
        ST_COPY,
        ST_ARGMAX,
        ST_TB_WR,
        ST_TB_RD,
        ST_OUT_RD,
        ST_OUT
    } fsm_t;

    // Metric plus weight, clamped to the metric range.
    function automatic logic signed [MET_W-1:0] sat_add(
        input logic signed [MET_W-1:0] a,
        input logic signed [WGT_W-1:0] b
    );
        logic signed [MET_W:0] s;
        s = {a[MET_W-1], a} + (MET_W+1)'(b);
        if (s[MET_W] != s[MET_W-1]) begin
            return s[MET_W] ? MET_MIN : MET_MAX;
        end
        return s[MET_W-1:0];
    endfunction

endpackage

// ===== src/hmm_viterbi_decoder.sv =====
// Log-domain Viterbi decoder. Load beats (tuser = kind 0..2) write one entry
// of the transition, emission or initial weight tables. An observation beat
// runs add-compare-select over the active states through one pipelined table
// read per cycle, limited by the single transition memory read port. The
// beat marked tlast then scans the states to find the best final state,
// traces back through the backpointer memory one stored step at a time, and
// then streams one state per stored step, first to last, as the receiver
// accepts them. New input is taken only when idle.
module hmm_viterbi_decoder
    import hmm_vit_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
    parameter int MAX_LEN     = DEF_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,      // states_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // from_state, to_state, symbol, weight
    input  logic [1:0]  s_tuser,       // kind
    input  logic        s_tlast,       // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // state_index
    output logic        m_tuser,       // overflow
    output logic        m_tlast        // last_res
);

    localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int CW   = $clog2(NUM_STATES + 1);
    localparam int TW   = $clog2(NUM_STATES * NUM_STATES);
    localparam int EW   = $clog2(NUM_STATES * NUM_SYMBOLS);
    localparam int BW   = (MAX_LEN * NUM_STATES > 1) ? $clog2(MAX_LEN * NUM_STATES) : 1;
    localparam int LW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNTW = $clog2(MAX_LEN + 1);

    // Input unpacking.
    logic [2:0]              in_from, in_to;
    logic [3:0]              in_sym;
    logic signed [WGT_W-1:0] in_wgt;
    kind_t                   in_kind;
    assign in_from = s_tdata[2:0];
    assign in_to   = s_tdata[5:3];
    assign in_sym  = s_tdata[9:6];
    assign in_wgt  = s_tdata[25:10];
    assign in_kind = kind_t'(s_tuser);

    logic s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // Control state.
    fsm_t            state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    logic [CNTW-1:0] step_reg;
    logic            ov_reg;
    logic            last_reg, first_reg, sym_ok_reg;
    logic [3:0]      sym_reg;
    logic            iss_on_reg, d_on_reg, d_lastj_reg, d_done_reg;
    logic [SW-1:0]   iss_i_reg, iss_j_reg, d_i_reg, d_j_reg;
    logic [SW-1:0]   scan_reg, cur_reg;
    logic signed [MET_W-1:0] best_reg, abest_reg;
    logic [SW-1:0]   arg_reg;
    logic [CNTW-1:0] t_reg;
    logic [LW-1:0]   out_idx_reg;

    // Active state count.
    logic [CW-1:0] n_act, n_m1;
    always_comb begin
        if (cfg_reg == '0) begin
            n_act = CW'(1);
        end else if (int'(cfg_reg) > NUM_STATES) begin
            n_act = CW'(NUM_STATES);
        end else begin
            n_act = CW'(cfg_reg);
        end
        n_m1 = n_act - CW'(1);
    end

    // Memories.
    logic signed [WGT_W-1:0] trans_mem [NUM_STATES*NUM_STATES];
    logic signed [WGT_W-1:0] emis_mem  [NUM_STATES*NUM_SYMBOLS];
    logic signed [WGT_W-1:0] init_mem  [NUM_STATES];
    logic [SW-1:0]           bp_mem    [MAX_LEN*NUM_STATES];
    logic [SW-1:0]           res_mem   [MAX_LEN];
    logic signed [WGT_W-1:0] trans_q, emis_q, init_q;
    logic [SW-1:0]           bp_q, res_q;

    logic signed [MET_W-1:0] pm_reg [NUM_STATES];
    logic signed [MET_W-1:0] nm_reg [NUM_STATES];

    logic is_load_idle;
    assign is_load_idle = s_acc && (in_kind != KIND_OBSERVE);

    logic [TW-1:0] trans_ra;
    logic [EW-1:0] emis_ra;
    logic [BW-1:0] bp_ra, bp_wa;
    assign trans_ra = TW'(int'(iss_j_reg) * NUM_STATES + int'(iss_i_reg));
    assign emis_ra  = EW'(int'(iss_i_reg) * NUM_SYMBOLS + int'(sym_reg));
    assign bp_ra    = BW'((int'(t_reg) - 1) * NUM_STATES + int'(cur_reg));
    assign bp_wa    = BW'(int'(step_reg) * NUM_STATES + int'(d_i_reg));

    always_ff @(posedge aclk) begin
        if (is_load_idle && in_kind == KIND_TRANS && int'(in_from) < NUM_STATES &&
            int'(in_to) < NUM_STATES) begin
            trans_mem[TW'(int'(in_from) * NUM_STATES + int'(in_to))] <= in_wgt;
        end
        trans_q <= trans_mem[trans_ra];
    end

    always_ff @(posedge aclk) begin
        if (is_load_idle && in_kind == KIND_EMIS && int'(in_from) < NUM_STATES &&
            int'(in_sym) < NUM_SYMBOLS) begin
            emis_mem[EW'(int'(in_from) * NUM_SYMBOLS + int'(in_sym))] <= in_wgt;
        end
        emis_q <= emis_mem[emis_ra];
    end

    always_ff @(posedge aclk) begin
        if (is_load_idle && in_kind == KIND_INIT && int'(in_from) < NUM_STATES) begin
            init_mem[SW'(in_from)] <= in_wgt;
        end
        init_q <= init_mem[iss_i_reg];
    end

    // Add-compare-select on the table data read in the cycle before.
    logic signed [WGT_W-1:0] emis_w;
    logic signed [MET_W-1:0] cand, best_new, met_new, init_met;
    logic                    take;
    logic [SW-1:0]           arg_new;
    always_comb begin
        emis_w   = sym_ok_reg ? emis_q : LOG_ZERO;
        cand     = sat_add(pm_reg[d_j_reg], trans_q);
        take     = (d_j_reg == '0) || (cand > best_reg);
        best_new = take ? cand : best_reg;
        arg_new  = take ? d_j_reg : arg_reg;
        met_new  = sat_add(best_new, emis_w);
        init_met = sat_add(MET_W'(init_q), emis_w);
    end

    logic bp_we;
    assign bp_we = (state_reg == ST_ACS) && d_on_reg && d_lastj_reg;

    always_ff @(posedge aclk) begin
        if (bp_we) begin
            bp_mem[bp_wa] <= arg_new;
        end
        bp_q <= bp_mem[bp_ra];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_TB_WR) begin
            res_mem[LW'(t_reg - CNTW'(1))] <= cur_reg;
        end
        res_q <= res_mem[out_idx_reg];
    end

    // Next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_kind == KIND_OBSERVE) begin
                    if (int'(step_reg) >= MAX_LEN) begin
                        state_next = s_tlast ? ST_ARGMAX : ST_IDLE;
                    end else begin
                        state_next = (step_reg == '0) ? ST_INIT : ST_ACS;
                    end
                end
            end
            ST_INIT: begin
                if (d_on_reg && d_done_reg) begin
                    state_next = last_reg ? ST_ARGMAX : ST_IDLE;
                end
            end
            ST_ACS: begin
                if (d_on_reg && d_done_reg) begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:   state_next = last_reg ? ST_ARGMAX : ST_IDLE;
            ST_ARGMAX: begin
                if (CW'(scan_reg) == n_m1) begin
                    state_next = ST_TB_WR;
                end
            end
            ST_TB_WR:  state_next = (t_reg > CNTW'(1)) ? ST_TB_RD : ST_OUT_RD;
            ST_TB_RD:  state_next = ST_TB_WR;
            ST_OUT_RD: state_next = ST_OUT;
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = m_tlast ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {5'd0, 3'(res_q)};
    assign m_tuser = ov_reg;
    assign m_tlast = (CNTW'(out_idx_reg) == step_reg - CNTW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= CFG_W'(8);
            step_reg   <= '0;
            ov_reg     <= 1'b0;
            iss_on_reg <= 1'b0;
            d_on_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end

            // Read issue for the table pipeline.
            if (s_acc && in_kind == KIND_OBSERVE) begin
                last_reg   <= s_tlast;
                sym_reg    <= in_sym;
                sym_ok_reg <= int'(in_sym) < NUM_SYMBOLS;
                first_reg  <= (step_reg == '0);
                iss_i_reg  <= '0;
                iss_j_reg  <= '0;
                if (int'(step_reg) >= MAX_LEN) begin
                    ov_reg <= 1'b1;
                end else begin
                    iss_on_reg <= 1'b1;
                end
            end else if (iss_on_reg) begin
                if (first_reg || CW'(iss_j_reg) == n_m1) begin
                    iss_j_reg <= '0;
                    if (CW'(iss_i_reg) == n_m1) begin
                        iss_on_reg <= 1'b0;
                    end else begin
                        iss_i_reg <= iss_i_reg + SW'(1);
                    end
                end else begin
                    iss_j_reg <= iss_j_reg + SW'(1);
                end
            end
            d_on_reg    <= iss_on_reg;
            d_i_reg     <= iss_i_reg;
            d_j_reg     <= iss_j_reg;
            d_lastj_reg <= first_reg || CW'(iss_j_reg) == n_m1;
            d_done_reg  <= (first_reg || CW'(iss_j_reg) == n_m1) &&
                           CW'(iss_i_reg) == n_m1;

            if (d_on_reg && d_done_reg &&
                (state_reg == ST_INIT || state_reg == ST_ACS)) begin
                step_reg <= step_reg + CNTW'(1);
            end

            if (m_acc && m_tlast) begin
                step_reg <= '0;
                ov_reg   <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_INIT && d_on_reg) begin
            pm_reg[d_i_reg] <= init_met;
        end
        if (state_reg == ST_ACS && d_on_reg) begin
            best_reg <= best_new;
            arg_reg  <= arg_new;
            if (d_lastj_reg) begin
                nm_reg[d_i_reg] <= met_new;
            end
        end
        // Metrics of states outside the active set keep their old values.
        if (state_reg == ST_COPY) begin
            for (int k = 0; k < NUM_STATES; k++) begin
                if (k < int'(n_act)) begin
                    pm_reg[k] <= nm_reg[k];
                end
            end
        end

        if (state_reg == ST_IDLE) begin
            scan_reg <= '0;
        end else if (state_reg == ST_ARGMAX) begin
            scan_reg <= scan_reg + SW'(1);
            if (scan_reg == '0 || pm_reg[scan_reg] > abest_reg) begin
                abest_reg <= pm_reg[scan_reg];
                cur_reg   <= scan_reg;
            end
            t_reg <= step_reg;
        end else if (state_reg == ST_TB_RD) begin
            cur_reg <= (int'(bp_q) < NUM_STATES) ? bp_q : '0;
            t_reg   <= t_reg - CNTW'(1);
        end

        if (state_reg == ST_TB_WR) begin
            out_idx_reg <= '0;
        end else if (m_acc) begin
            out_idx_reg <= out_idx_reg + LW'(1);
        end
    end

    // Checks.
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(step_reg) <= MAX_LEN)
        else $error("step count past maximum length");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && m_tlast |=> step_reg == '0 && !ov_reg && s_tready)
        else $error("sequence not cleared after final result");

    a_issue_in_acs: assert property (@(posedge aclk) disable iff (!aresetn)
        d_on_reg |-> state_reg == ST_INIT || state_reg == ST_ACS)
        else $error("table pipeline busy outside metric update");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import hmm_vit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Tables are loaded for this many states and symbols; observations and
    // state counts stay inside them.
    localparam int TB_STATES = 4;
    localparam int TB_SYMS   = 4;

    typedef struct {
        kind_t              kind;
        logic [2:0]         from_st;
        logic [2:0]         to_st;
        logic [3:0]         sym;
        logic signed [15:0] wgt;
        logic               last;
    } hmm_beat_t;

    typedef struct {
        logic [2:0] state_idx;
        logic       last_res;
        logic       ovf;
    } path_state_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    hmm_viterbi_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    hmm_beat_t   pending_beats[$];
    hmm_beat_t   cur_beat;
    path_state_t expected_states[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int beats_accepted;
    int beats_issued;
    int mismatches;
    int results_seen;
    int seqs_decoded;
    int overflow_seqs;

    // Predictor state.
    int       active_n;
    int       trans_w[64];
    int       emit_w[128];
    int       init_w[8];
    int       path_score[8];
    int       next_score[8];
    bit [2:0] back_ptr[512];
    int       steps_taken;
    bit       truncated;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_metric(longint s);
        if (s < -(longint'(1) << 23)) return -(1 << 23);
        if (s > (longint'(1) << 23) - 1) return (1 << 23) - 1;
        return int'(s);
    endfunction

    task automatic decode_step(input hmm_beat_t b);
        int best;
        int cand;
        int arg;
        int cur;
        path_state_t res;
        path_state_t seq_res[$];
        case (b.kind)
            KIND_TRANS: trans_w[b.from_st * 8 + b.to_st] = b.wgt;
            KIND_EMIS:  emit_w[b.from_st * 16 + b.sym] = b.wgt;
            KIND_INIT:  init_w[b.from_st] = b.wgt;
            default: begin
                if (steps_taken >= 64) begin
                    truncated = 1'b1;
                end else if (steps_taken == 0) begin
                    for (int i = 0; i < active_n; i++)
                        path_score[i] = clamp_metric(init_w[i] + emit_w[i * 16 + b.sym]);
                    steps_taken++;
                end else begin
                    for (int i = 0; i < active_n; i++) begin
                        best = clamp_metric(path_score[0] + trans_w[i]);
                        arg = 0;
                        for (int j = 1; j < active_n; j++) begin
                            cand = clamp_metric(path_score[j] + trans_w[j * 8 + i]);
                            if (cand > best) begin
                                best = cand;
                                arg = j;
                            end
                        end
                        next_score[i] = clamp_metric(best + emit_w[i * 16 + b.sym]);
                        back_ptr[steps_taken * 8 + i] = arg[2:0];
                    end
                    for (int i = 0; i < active_n; i++) path_score[i] = next_score[i];
                    steps_taken++;
                end
                if (b.last) begin
                    if (steps_taken > 0) begin
                        cur = 0;
                        for (int j = 1; j < active_n; j++)
                            if (path_score[j] > path_score[cur]) cur = j;
                        // Walk back from the final step, then emit first to last.
                        for (int t = steps_taken; t > 0; t--) begin
                            res.state_idx = cur[2:0];
                            res.last_res  = (t == steps_taken);
                            res.ovf       = truncated;
                            seq_res.push_front(res);
                            if (t > 1) cur = back_ptr[(t - 1) * 8 + cur];
                        end
                        foreach (seq_res[k]) expected_states.push_back(seq_res[k]);
                        seqs_decoded++;
                        if (truncated) overflow_seqs++;
                    end
                    steps_taken = 0;
                    truncated = 1'b0;
                end
            end
        endcase
    endtask

    // Input driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beats_accepted == beats_issued) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat = pending_beats.pop_front();
                s_tdata  <= {6'd0, cur_beat.wgt, cur_beat.sym,
                             cur_beat.to_st, cur_beat.from_st};
                s_tuser  <= cur_beat.kind;
                s_tlast  <= cur_beat.last;
                s_tvalid <= 1'b1;
                beats_issued <= beats_issued + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with an occasional long hold-off.
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 1500;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on accepted input beats and checks result beats.
    always @(posedge aclk) begin
        path_state_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                active_n = (cfg_data == 0) ? 1 : (cfg_data > 8) ? 8 : int'(cfg_data);
            if (s_tvalid && s_tready) begin
                decode_step(cur_beat);
                beats_accepted <= beats_accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_states.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: state %0d last %0b ovf %0b",
                                 m_tdata[2:0], m_tlast, m_tuser);
                end else begin
                    want = expected_states.pop_front();
                    if (m_tdata[2:0] !== want.state_idx || m_tlast !== want.last_res
                            || m_tuser !== want.ovf) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: expected state %0d last %0b ovf %0b",
                                     $realtime, want.state_idx, want.last_res, want.ovf);
                            $display("    got state %0d last %0b ovf %0b",
                                     m_tdata[2:0], m_tlast, m_tuser);
                        end
                    end
                end
            end
        end
    end

    task automatic add_beat(kind_t k, int f, int t, int sy, int w, bit lst);
        hmm_beat_t b;
        b.kind = k;
        b.from_st = f[2:0];
        b.to_st = t[2:0];
        b.sym = sy[3:0];
        b.wgt = w[15:0];
        b.last = lst;
        pending_beats.push_back(b);
    endtask

    // Coarse steps make equal candidates, and so ties, frequent.
    function automatic int rand_weight();
        case ($urandom_range(9))
            0: return -32768;
            1: return 0;
            2: return $urandom_range(32767);
            3: return int'($signed(16'($urandom)));
            default: return -256 * int'($urandom_range(4));
        endcase
    endfunction

    task automatic load_tables();
        for (int f = 0; f < TB_STATES; f++) begin
            add_beat(KIND_INIT, f, $urandom_range(7), $urandom_range(15),
                     rand_weight(), $urandom_range(1));
            for (int t = 0; t < TB_STATES; t++)
                add_beat(KIND_TRANS, f, t, $urandom_range(15), rand_weight(), 0);
            for (int s = 0; s < TB_SYMS; s++)
                add_beat(KIND_EMIS, f, $urandom_range(7), s, rand_weight(), 0);
        end
    endtask

    // A sequence of observations with occasional table updates mixed in.
    task automatic add_sequence(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                add_beat(kind_t'($urandom_range(2)), $urandom_range(7), $urandom_range(7),
                         $urandom_range(15), rand_weight(), $urandom_range(1));
            add_beat(KIND_OBSERVE, $urandom_range(7), $urandom_range(7),
                     $urandom_range(TB_SYMS - 1), int'($urandom), i == len - 1);
        end
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_states.size() > 0)
            @(posedge aclk);
        // An unmarked observation may still be in progress.
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_states(int n);
        @(negedge aclk);
        cfg_data <= n[3:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int cfg_list[6];
        cfg_list = '{0, 2, 4, 3, 4, 3};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 4'd8;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_TRANS;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 87;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        beats_accepted = 0;
        beats_issued = 0;
        mismatches = 0;
        results_seen = 0;
        seqs_decoded = 0;
        overflow_seqs = 0;
        active_n = 8;
        steps_taken = 0;
        truncated = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme weights, and a last flag on a load beat.
        write_states(TB_STATES);
        load_tables();
        add_beat(KIND_INIT, 3, 0, 0, -32768, 1);
        add_beat(KIND_EMIS, 3, 0, 3, 32767, 0);
        add_beat(KIND_TRANS, 3, 3, 3, -32768, 0);
        add_sequence(1);
        add_sequence(2);
        drain();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 35 : (p < 4) ? 87 : 0;
            recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 35 : 0;
            write_states(cfg_list[p]);
            if (p == 4) begin
                // Results are held off while the next sequence waits at the input.
                hold_requests++;
                add_sequence(2);
                add_sequence(2);
            end else if (p == 5) begin
                // Longer than the backpointer store, so the tail is dropped.
                add_sequence(66);
            end else begin
                add_sequence($urandom_range(1, 3));
            end
            drain();
        end

        $display("Covered table loads and %0d decoded sequences (%0d truncated),",
                 seqs_decoded, overflow_seqs);
        $display("with %0d result beats under stalls and several state counts.",
                 results_seen);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/hmm_vit_pkg.sv
src/hmm_viterbi_decoder.sv
sim/testbench.sv
